/* design/bez_pkg.sv */
// Shared types and constants for the cubic Bezier splitter.
// Used by the top, the merge stage and the checker; depends on nothing.
package bez_pkg;

    localparam int COORD_W = 32;
    localparam int FRAC_W  = 16;

    localparam int NUM_POINTS = 7;
    localparam logic [2:0] FIRST_POINT = 3'd0;
    localparam logic [2:0] LAST_POINT  = 3'd6;

    typedef struct packed {
        logic signed [COORD_W-1:0] start_x;
        logic signed [COORD_W-1:0] start_y;
        logic signed [COORD_W-1:0] ctrl1_x;
        logic signed [COORD_W-1:0] ctrl1_y;
        logic signed [COORD_W-1:0] ctrl2_x;
        logic signed [COORD_W-1:0] ctrl2_y;
        logic signed [COORD_W-1:0] end_x;
        logic signed [COORD_W-1:0] end_y;
        logic        [FRAC_W:0]    split_at;
    } curve_t;

    typedef struct packed {
        logic        [2:0]         point_index;
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic                      last_point;
    } point_t;

endpackage

/* design/bez_lerp.sv */
// One interpolation lane: res = a + floor((b - a) * u / 2^FRAC_WIDTH).
// Three register stages (difference, product, sum); depends on nothing else.
module bez_lerp #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_WIDTH  = 16
) (
    input  logic                          clk,
    input  logic                          en,
    input  logic signed [COORD_WIDTH-1:0] a,
    input  logic signed [COORD_WIDTH-1:0] b,
    input  logic        [FRAC_WIDTH:0]    u,
    output logic signed [COORD_WIDTH-1:0] res
);
    localparam int D_W = COORD_WIDTH + 1;
    localparam int U_W = FRAC_WIDTH + 2;
    localparam int P_W = D_W + U_W;

    logic signed [D_W-1:0]         diff_reg;
    logic signed [COORD_WIDTH-1:0] a1_reg;
    logic signed [U_W-1:0]         u1_reg;
    logic signed [P_W-1:0]         prod_reg;
    logic signed [COORD_WIDTH-1:0] a2_reg;
    logic signed [COORD_WIDTH-1:0] res_reg;

    logic signed [D_W-1:0]         diff_next;
    logic signed [P_W-1:0]         prod_next;
    logic signed [COORD_WIDTH-1:0] res_next;

    assign diff_next = D_W'(b) - D_W'(a);
    assign prod_next = P_W'(diff_reg) * P_W'(u1_reg);
    // floor shift of the product; the sum lands back in range while u is at most 1.0
    assign res_next  = a2_reg + signed'(prod_reg[FRAC_WIDTH +: COORD_WIDTH]);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            diff_reg <= diff_next;
            a1_reg   <= a;
            u1_reg   <= signed'({1'b0, u});
            prod_reg <= prod_next;
            a2_reg   <= a1_reg;
            res_reg  <= res_next;
        end
    end

    assign res = res_reg;

endmodule

/* design/bez_delay.sv */
// Enabled shift line that carries side values alongside the interpolation lanes.
// Generic width and depth; depends on nothing else.
module bez_delay #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 3
) (
    input  logic             clk,
    input  logic             en,
    input  logic [WIDTH-1:0] din,
    output logic [WIDTH-1:0] dout
);
    logic [WIDTH-1:0] tap_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tap_reg[0] <= din;
            for (int i = 1; i < DEPTH; i++)
            begin
                tap_reg[i] <= tap_reg[i-1];
            end
        end
    end

    assign dout = tap_reg[DEPTH-1];

endmodule

/* design/bez_merge.sv */
// Merge stage: gathers the seven control points from the lanes and sends them
// out one beat at a time. Depends on bez_pkg.
module bez_merge #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          load,
    input  logic signed [COORD_WIDTH-1:0] px_in [7],
    input  logic signed [COORD_WIDTH-1:0] py_in [7],
    output logic                          free,
    output logic                          point_valid,
    input  logic                          point_stall,
    output bez_pkg::point_t               point
);
    import bez_pkg::*;

    logic signed [COORD_WIDTH-1:0] px_reg [NUM_POINTS];
    logic signed [COORD_WIDTH-1:0] py_reg [NUM_POINTS];
    logic [2:0] cnt_reg, cnt_next;
    logic       full_reg, full_next;
    logic       take;
    logic       at_last;

    assign take    = full_reg && !point_stall;
    assign at_last = (cnt_reg == LAST_POINT);
    assign free    = !full_reg || (take && at_last);

    always_comb
    begin
        cnt_next  = cnt_reg;
        full_next = full_reg;
        if (take)
        begin
            if (at_last)
            begin
                cnt_next  = FIRST_POINT;
                full_next = 1'b0;
            end
            else
            begin
                cnt_next = cnt_reg + 3'd1;
            end
        end
        if (load)
        begin
            cnt_next  = FIRST_POINT;
            full_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= FIRST_POINT;
            full_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            full_reg <= full_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            for (int i = 0; i < NUM_POINTS; i++)
            begin
                px_reg[i] <= px_in[i];
                py_reg[i] <= py_in[i];
            end
        end
    end

    assign point_valid       = full_reg;
    assign point.point_index = cnt_reg;
    assign point.point_x     = COORD_W'(px_reg[cnt_reg]);
    assign point.point_y     = COORD_W'(py_reg[cnt_reg]);
    assign point.last_point  = at_last;

endmodule

/* design/cubic_bezier_split_top.sv */
// Cubic Bezier splitter: de Casteljau subdivision at a split position u.
// Depends on bez_pkg, bez_lerp, bez_delay and bez_merge.
//
// Each curve beat (four signed fixed-point control points and u, saturated to
// 1.0) yields seven point beats, the control points of the two halves in order
// 0 to 6, with last_point set on point 6. Three interpolation levels of three
// register stages each run six, four and two lanes (x and y side by side), and
// the last level's sum stage loads the merge stage. The merge stage sends one
// point per cycle while point_stall is low and takes the next curve as its
// last point leaves; the next curves keep moving through the lanes while points
// of earlier ones are still being sent, until one waits in the last lane stage.
module cubic_bezier_split_top #(
    parameter int COORD_WIDTH = bez_pkg::COORD_W,
    parameter int FRAC_WIDTH  = bez_pkg::FRAC_W
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             curve_valid,
    output logic             curve_stall,
    input  bez_pkg::curve_t  curve,
    output logic             point_valid,
    input  logic             point_stall,
    output bez_pkg::point_t  point
);
    import bez_pkg::*;

    localparam int W     = COORD_WIDTH;
    localparam int U_W   = FRAC_WIDTH + 1;
    localparam int DEPTH = 9;
    localparam logic [U_W-1:0] U_ONE = {1'b1, {FRAC_WIDTH{1'b0}}};

    logic             adv;
    logic             free;
    logic [DEPTH-1:0] vld_reg, vld_next;

    logic [U_W-1:0]        u_in, u_l2, u_l3;
    logic signed [W-1:0]   p_in [4][2];
    logic signed [W-1:0]   l01  [2];
    logic signed [W-1:0]   ctr  [2];
    logic signed [W-1:0]   l23  [2];
    logic signed [W-1:0]   pt2  [2];
    logic signed [W-1:0]   pt4  [2];
    logic signed [W-1:0]   pt3  [2];
    logic [4*W-1:0]        ends_d, l1_d, l2_d;
    logic signed [W-1:0]   px_all [7];
    logic signed [W-1:0]   py_all [7];

    // stall the whole lane pipeline only when its last stage cannot unload
    assign adv         = !vld_reg[DEPTH-1] || free;
    assign curve_stall = !adv;
    assign vld_next    = {vld_reg[DEPTH-2:0], curve_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= vld_next;
        end
    end

    assign u_in = (U_W'(curve.split_at) > U_ONE) ? U_ONE : U_W'(curve.split_at);

    assign p_in[0][0] = W'(curve.start_x);
    assign p_in[0][1] = W'(curve.start_y);
    assign p_in[1][0] = W'(curve.ctrl1_x);
    assign p_in[1][1] = W'(curve.ctrl1_y);
    assign p_in[2][0] = W'(curve.ctrl2_x);
    assign p_in[2][1] = W'(curve.ctrl2_y);
    assign p_in[3][0] = W'(curve.end_x);
    assign p_in[3][1] = W'(curve.end_y);

    bez_delay #(.WIDTH(U_W), .DEPTH(3)) u_dly_u2 (
        .clk(clk), .en(adv), .din(u_in), .dout(u_l2)
    );
    bez_delay #(.WIDTH(U_W), .DEPTH(3)) u_dly_u3 (
        .clk(clk), .en(adv), .din(u_l2), .dout(u_l3)
    );

    for (genvar ax = 0; ax < 2; ax++)
    begin : g_axis
        bez_lerp #(.COORD_WIDTH(W), .FRAC_WIDTH(FRAC_WIDTH)) u_l01 (
            .clk(clk), .en(adv), .a(p_in[0][ax]), .b(p_in[1][ax]), .u(u_in),
            .res(l01[ax])
        );
        bez_lerp #(.COORD_WIDTH(W), .FRAC_WIDTH(FRAC_WIDTH)) u_ctr (
            .clk(clk), .en(adv), .a(p_in[1][ax]), .b(p_in[2][ax]), .u(u_in),
            .res(ctr[ax])
        );
        bez_lerp #(.COORD_WIDTH(W), .FRAC_WIDTH(FRAC_WIDTH)) u_l23 (
            .clk(clk), .en(adv), .a(p_in[2][ax]), .b(p_in[3][ax]), .u(u_in),
            .res(l23[ax])
        );
        bez_lerp #(.COORD_WIDTH(W), .FRAC_WIDTH(FRAC_WIDTH)) u_pt2 (
            .clk(clk), .en(adv), .a(l01[ax]), .b(ctr[ax]), .u(u_l2),
            .res(pt2[ax])
        );
        bez_lerp #(.COORD_WIDTH(W), .FRAC_WIDTH(FRAC_WIDTH)) u_pt4 (
            .clk(clk), .en(adv), .a(ctr[ax]), .b(l23[ax]), .u(u_l2),
            .res(pt4[ax])
        );
        bez_lerp #(.COORD_WIDTH(W), .FRAC_WIDTH(FRAC_WIDTH)) u_pt3 (
            .clk(clk), .en(adv), .a(pt2[ax]), .b(pt4[ax]), .u(u_l3),
            .res(pt3[ax])
        );
    end

    // carry the end points and the early levels until the last level lands
    bez_delay #(.WIDTH(4*W), .DEPTH(9)) u_dly_ends (
        .clk(clk), .en(adv),
        .din({p_in[0][0], p_in[0][1], p_in[3][0], p_in[3][1]}),
        .dout(ends_d)
    );
    bez_delay #(.WIDTH(4*W), .DEPTH(6)) u_dly_l1 (
        .clk(clk), .en(adv),
        .din({l01[0], l01[1], l23[0], l23[1]}),
        .dout(l1_d)
    );
    bez_delay #(.WIDTH(4*W), .DEPTH(3)) u_dly_l2 (
        .clk(clk), .en(adv),
        .din({pt2[0], pt2[1], pt4[0], pt4[1]}),
        .dout(l2_d)
    );

    assign px_all[0] = signed'(ends_d[3*W +: W]);
    assign py_all[0] = signed'(ends_d[2*W +: W]);
    assign px_all[1] = signed'(l1_d[3*W +: W]);
    assign py_all[1] = signed'(l1_d[2*W +: W]);
    assign px_all[2] = signed'(l2_d[3*W +: W]);
    assign py_all[2] = signed'(l2_d[2*W +: W]);
    assign px_all[3] = pt3[0];
    assign py_all[3] = pt3[1];
    assign px_all[4] = signed'(l2_d[W +: W]);
    assign py_all[4] = signed'(l2_d[0 +: W]);
    assign px_all[5] = signed'(l1_d[W +: W]);
    assign py_all[5] = signed'(l1_d[0 +: W]);
    assign px_all[6] = signed'(ends_d[W +: W]);
    assign py_all[6] = signed'(ends_d[0 +: W]);

    bez_merge #(.COORD_WIDTH(W)) u_merge (
        .clk(clk),
        .rst_n(rst_n),
        .load(vld_reg[DEPTH-1] && free),
        .px_in(px_all),
        .py_in(py_all),
        .free(free),
        .point_valid(point_valid),
        .point_stall(point_stall),
        .point(point)
    );

endmodule

/* design/bez_checker.sv */
// Port-level checks on the point sequence of the Bezier splitter, with the
// bind that attaches them to cubic_bezier_split_top. Depends on bez_pkg.
module bez_checker (
    input logic            clk,
    input logic            rst_n,
    input logic            curve_valid,
    input logic            curve_stall,
    input bez_pkg::curve_t curve,
    input logic            point_valid,
    input logic            point_stall,
    input bez_pkg::point_t point
);
    import bez_pkg::*;

    logic point_take;
    assign point_take = point_valid && !point_stall;

    // a stalled curve beat holds until taken
    a_curve_hold: assert property (@(posedge clk) disable iff (!rst_n)
        curve_valid && curve_stall |=> curve_valid && $stable(curve))
        else $error("stalled curve beat changed");

    // the flag marks the seventh point and nothing else
    a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
        point_valid |-> (point.last_point == (point.point_index == LAST_POINT)))
        else $error("last_point does not match point_index");

    // a stalled beat holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        point_valid && point_stall |=> point_valid && $stable(point))
        else $error("stalled point beat changed");

    // the points of one curve follow back to back in order
    a_next_point: assert property (@(posedge clk) disable iff (!rst_n)
        point_take && !point.last_point |=>
            point_valid && (point.point_index == $past(point.point_index) + 3'd1))
        else $error("point sequence broken");

    // a new curve always starts at point zero
    a_restart: assert property (@(posedge clk) disable iff (!rst_n)
        point_take && point.last_point |=>
            !point_valid || (point.point_index == FIRST_POINT))
        else $error("curve did not start at point zero");

endmodule

bind cubic_bezier_split_top bez_checker u_bez_checker (
    .clk(clk),
    .rst_n(rst_n),
    .curve_valid(curve_valid),
    .curve_stall(curve_stall),
    .curve(curve),
    .point_valid(point_valid),
    .point_stall(point_stall),
    .point(point)
);
